@@ hdl/coin_change_combination_count_unit_defines.svh @@
// assertion macros for the coin change combination counter
// no dependencies; expects clk and rst in the including scope
`ifndef COIN_CHANGE_COMBINATION_COUNT_UNIT_DEFINES_SVH
`define COIN_CHANGE_COMBINATION_COUNT_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ccc_pkg.sv @@
// shared types and constants for the coin change combination counter
// no dependencies
package ccc_pkg;

  localparam int COIN_W   = 16;
  localparam int TARGET_W = 12;
  localparam int COUNT_W  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_UPDATE,
    ST_DRAIN,
    ST_READ,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sum;
    logic               ovf;
  } sat_result_t;

endpackage

@@ hdl/ccc_channels.sv @@
// valid/ready channel interfaces for coin beats and result beats
// depends on ccc_pkg
interface ccc_coin_if;
  logic                        valid;
  logic                        ready;
  logic [ccc_pkg::COIN_W-1:0]  coin_value;
  logic                        first_coin;
  logic                        last_coin;

  modport source (output valid, coin_value, first_coin, last_coin, input ready);
  modport sink   (input valid, coin_value, first_coin, last_coin, output ready);
endinterface

interface ccc_result_if;
  logic                        valid;
  logic                        ready;
  logic [ccc_pkg::COUNT_W-1:0] way_count;
  logic                        count_saturated;

  modport source (output valid, way_count, count_saturated, input ready);
  modport sink   (input valid, way_count, count_saturated, output ready);
endinterface

@@ hdl/ccc_ram.sv @@
// generic memory: one write port, two read ports, registered read data
// no dependencies
module ccc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/ccc_sat_add.sv @@
// saturating 32-bit adder shared by every table update
// depends on ccc_pkg
module ccc_sat_add (
  input  logic [ccc_pkg::COUNT_W-1:0] a,
  input  logic [ccc_pkg::COUNT_W-1:0] b,
  output ccc_pkg::sat_result_t        res
);
  import ccc_pkg::*;

  logic [COUNT_W:0] full_sum;

  assign full_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    res.ovf = full_sum[COUNT_W];
    res.sum = full_sum[COUNT_W] ? {COUNT_W{1'b1}} : full_sum[COUNT_W-1:0];
  end

endmodule

@@ hdl/coin_change_combination_count_unit.sv @@
// top level of the coin change combination counter: sequencer, table, result register
// depends on ccc_pkg, ccc_channels, ccc_ram, ccc_sat_add and the assertion header
//
//   port        dir   beat contents
//   ----------  ----  ------------------------------------------------
//   coin_in     in    coin_value[15:0], first_coin, last_coin
//   result_out  out   way_count[31:0], count_saturated
//   cfg_wr_*    in    target_amount[11:0], written when cfg_wr_en is high
//
// one coin beat at a time; with t = min(target_amount, MAX_AMOUNT-1) and coin c:
//   first coin restarts the table with a sweep over entries 0..t
//   update pass over amounts c..t, one read-modify-write per amount, all through
//   the single saturating adder and the two-read/one-write table memory
//   last coin then reads ways[t] through the read and report states
// no table clearing after reset: the table is written by the restart sweep
// a finished result sits in the output register; only a second result waiting
// on a stalled sink holds the sequencer in the report state
`include "coin_change_combination_count_unit_defines.svh"

module coin_change_combination_count_unit #(
  parameter int MAX_AMOUNT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ccc_pkg::TARGET_W-1:0]  cfg_wr_data,
  ccc_coin_if.sink                      coin_in,
  ccc_result_if.source                  result_out
);
  import ccc_pkg::*;

  localparam int AW = $clog2(MAX_AMOUNT);
  // wide enough for any coin, any target and the top table index
  localparam int CW = (COIN_W > AW ? COIN_W : AW) + 1;

  // configuration register
  logic [TARGET_W-1:0] target_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_amount <= '0;
    end else if (cfg_wr_en) begin
      target_amount <= cfg_wr_data;
    end
  end

  // target clamped to the last table entry
  logic [CW-1:0] tgt_wide;
  logic [CW-1:0] max_idx;
  logic [AW-1:0] eff_target;

  assign tgt_wide   = CW'(target_amount);
  assign max_idx    = CW'(MAX_AMOUNT - 1);
  assign eff_target = (tgt_wide > max_idx) ? AW'(max_idx) : AW'(tgt_wide);

  // coin beat acceptance
  logic accept;
  logic coin_fits;

  assign accept    = coin_in.valid && coin_in.ready;
  assign coin_fits = (coin_in.coin_value != '0) &&
                     (CW'(coin_in.coin_value) <= CW'(eff_target));

  // sequencer state
  state_t        state, state_next;
  logic [AW-1:0] amt, amt_next;
  logic [AW-1:0] tgt_r;
  logic [AW-1:0] coin_r;
  logic          upd_r;
  logic          last_r;
  logic          sat_seen;

  // write stage of the update pipeline
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic          fwd_hit;
  logic [COUNT_W-1:0] fwd_data;

  // output register
  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  logic               res_sat;
  logic               res_load;

  // table memory ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr_a;
  logic [AW-1:0]      ram_raddr_b;
  logic [COUNT_W-1:0] ram_rdata_a;
  logic [COUNT_W-1:0] ram_rdata_b;
  logic [COUNT_W-1:0] lower_way;
  sat_result_t        add_res;

  assign coin_in.ready = (state == ST_IDLE);

  // port a reads ways[a] during the pass, ways[t] for the result
  assign ram_raddr_a = (state == ST_READ || state == ST_REPORT) ? tgt_r : amt;
  // port b reads ways[a - coin]
  assign ram_raddr_b = amt - coin_r;

  // ways[a - coin] may have been written in the cycle its read was issued
  assign lower_way = fwd_hit ? fwd_data : ram_rdata_b;

  ccc_sat_add u_add (
    .a   (ram_rdata_a),
    .b   (lower_way),
    .res (add_res)
  );

  // restart sweep writes 1 at entry 0, 0 elsewhere; otherwise the update write
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = amt;
      ram_wdata = COUNT_W'(amt == '0);
    end else begin
      ram_we    = s1_valid;
      ram_waddr = s1_addr;
      ram_wdata = add_res.sum;
    end
  end

  ccc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_AMOUNT)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // result goes out once the register is free or being emptied
  assign res_load = (state == ST_REPORT) && (!res_valid || result_out.ready);

  // next state and counter
  always_comb begin
    state_next = state;
    amt_next   = amt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (coin_in.first_coin) begin
            state_next = ST_CLEAR;
            amt_next   = '0;
          end else if (coin_fits) begin
            state_next = ST_UPDATE;
            amt_next   = AW'(coin_in.coin_value);
          end else if (coin_in.last_coin) begin
            state_next = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        if (amt == tgt_r) begin
          if (upd_r) begin
            state_next = ST_UPDATE;
            amt_next   = coin_r;
          end else if (last_r) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          amt_next = amt + 1'b1;
        end
      end
      ST_UPDATE: begin
        if (amt == tgt_r) begin
          state_next = ST_DRAIN;
        end else begin
          amt_next = amt + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = last_r ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counter and per-coin context
  always_ff @(posedge clk) begin
    amt <= amt_next;
    if (accept) begin
      tgt_r  <= eff_target;
      coin_r <= AW'(coin_in.coin_value);
      upd_r  <= coin_fits;
      last_r <= coin_in.last_coin;
    end
  end

  // update pipeline: reads issued in ST_UPDATE, sum written in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_UPDATE);
    end
    s1_addr  <= amt;
    fwd_hit  <= s1_valid && (s1_addr == ram_raddr_b);
    fwd_data <= add_res.sum;
  end

  // sticky saturation flag, cleared by a restart
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_seen <= 1'b0;
    end else if (accept && coin_in.first_coin) begin
      sat_seen <= 1'b0;
    end else if (s1_valid && add_res.ovf) begin
      sat_seen <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
    if (res_load) begin
      res_count <= ram_rdata_a;
      res_sat   <= sat_seen;
    end
  end

  assign result_out.valid           = res_valid;
  assign result_out.way_count       = res_count;
  assign result_out.count_saturated = res_sat;

  // update writes stay within the coin..target window
  `CCC_ASSERT_NOW(a_upd_window, s1_valid, (s1_addr <= tgt_r) && (s1_addr >= coin_r), "update write outside coin..target")
  // restart sweep never shares the write port with an update write
  `CCC_ASSERT_NOW(a_clear_no_upd, state == ST_CLEAR, !s1_valid, "update write during restart sweep")
  // an accepted coin that restarts, fits or is last starts work or a result read
  `CCC_ASSERT_NEXT(a_accept_busy, accept && (coin_in.first_coin || coin_fits || coin_in.last_coin), state != ST_IDLE, "accepted coin left sequencer idle")

endmodule
